/* hw/rtl/bcl_pkg.sv */
// Shared constants, register indexes and the result item type of the line rasteriser.
`default_nettype none
package bcl_pkg;

  // Field widths fixed by the item format
  localparam int LIM_W = 11;
  localparam int PT_W  = 11;
  localparam int CNT_W = 7;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_COORD_BITS = 12;

  // Depth of both internal queues
  localparam int QUEUE_DEPTH = 2;

  // Configuration register reset values
  localparam logic [LIM_W-1:0] ROW_LIMIT_RESET = 11'd480;
  localparam logic [LIM_W-1:0] COL_LIMIT_RESET = 11'd480;

  // Register indexes, taken from paddr[2]
  typedef enum logic {
    REG_ROW_LIMIT = 1'b0,
    REG_COL_LIMIT = 1'b1
  } reg_idx_t;

  // One result item
  typedef struct packed {
    logic [PT_W-1:0]  point_x;
    logic [PT_W-1:0]  point_y;
    logic             point_valid;
    logic             last_point;
    logic [CNT_W-1:0] point_count;
    logic             truncated;
  } result_t;

endpackage
`default_nettype wire

/* hw/rtl/bcl_fifo.sv */
// Small register-based queue used between the stages of the line rasteriser.
`default_nettype none
module bcl_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [NW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == NW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  // Store the incoming item
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/bcl_front.sv */
// Front end: takes a line request, works out deltas, directions and the major axis.
`default_nettype none
module bcl_front #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                         push,
  output logic                              full,
  input  wire logic signed [COORD_BITS-1:0] start_x,
  input  wire logic signed [COORD_BITS-1:0] start_y,
  input  wire logic signed [COORD_BITS-1:0] end_x,
  input  wire logic signed [COORD_BITS-1:0] end_y,
  input  wire logic                         setup_full,
  output logic                              setup_push,
  output logic [6*COORD_BITS+4:0]           setup_data
);
  import bcl_pkg::*;

  localparam int DW = COORD_BITS + 1;

  logic signed [DW-1:0] dx_s;
  logic signed [DW-1:0] dy_s;
  logic [DW-1:0]        adx;
  logic [DW-1:0]        ady;
  logic                 sx_neg;
  logic                 sy_neg;
  logic                 x_major;
  logic [DW-1:0]        dmaj;
  logic [DW-1:0]        dmin;

  // Accept while the setup queue has room
  assign full       = setup_full;
  assign setup_push = push && !setup_full;

  // Signed deltas and their magnitudes
  assign dx_s   = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
  assign dy_s   = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
  assign sx_neg = dx_s[DW-1];
  assign sy_neg = dy_s[DW-1];
  assign adx    = sx_neg ? $unsigned(-dx_s) : $unsigned(dx_s);
  assign ady    = sy_neg ? $unsigned(-dy_s) : $unsigned(dy_s);

  // Pick the major axis, ties go to x
  assign x_major = (ady <= adx);
  assign dmaj    = x_major ? adx : ady;
  assign dmin    = x_major ? ady : adx;

  assign setup_data = {x_major, sx_neg, sy_neg, dmaj, dmin, start_x, start_y, end_x, end_y};

endmodule
`default_nettype wire

/* hw/rtl/bcl_walker.sv */
// Back end: walks one line a point per cycle while the result queue has room and writes result items.
`default_nettype none
module bcl_walker #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 12
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [bcl_pkg::LIM_W-1:0] row_limit,
  input  wire logic [bcl_pkg::LIM_W-1:0] col_limit,
  input  wire logic [6*COORD_BITS+4:0]   setup_data,
  input  wire logic                      setup_empty,
  output logic                           setup_pop,
  input  wire logic                      res_full,
  output logic                           res_push,
  output bcl_pkg::result_t               res_data
);
  import bcl_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int CW    = C + 1;
  localparam int DW    = C + 1;
  localparam int EW    = C + 3;
  localparam int CMP_W = (CW - 1 > LIM_W) ? CW - 1 : LIM_W;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t               state;
  state_t               state_next;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [CW-1:0] ex;
  logic signed [CW-1:0] ey;
  logic signed [EW-1:0] err;
  logic [DW-1:0]        dmaj;
  logic [DW-1:0]        dmin;
  logic                 sx_neg;
  logic                 sy_neg;
  logic                 x_major;
  logic [CNT_W-1:0]     n;

  logic                 load;
  logic                 emit;
  logic                 last;
  logic                 cur_in;
  logic                 next_in;
  logic                 at_end;
  logic                 cap;
  logic                 step_minor;
  logic [CNT_W-1:0]     cnt1;
  logic signed [EW-1:0] e1;
  logic signed [EW-1:0] err_next;
  logic signed [CW-1:0] x_step;
  logic signed [CW-1:0] y_step;
  logic signed [CW-1:0] x_next;
  logic signed [CW-1:0] y_next;

  // Unpacked setup fields
  logic                 s_x_major;
  logic                 s_sx_neg;
  logic                 s_sy_neg;
  logic [DW-1:0]        s_dmaj;
  logic [DW-1:0]        s_dmin;
  logic signed [C-1:0]  s_x0;
  logic signed [C-1:0]  s_y0;
  logic signed [C-1:0]  s_ex;
  logic signed [C-1:0]  s_ey;

  function automatic logic in_image(input logic signed [CW-1:0] v,
                                    input logic [LIM_W-1:0] lim);
    in_image = !v[CW-1] && (CMP_W'(v[CW-2:0]) < CMP_W'(lim));
  endfunction

  assign {s_x_major, s_sx_neg, s_sy_neg, s_dmaj, s_dmin, s_x0, s_y0, s_ex, s_ey} = setup_data;

  // Bresenham step from the current point
  assign e1         = err + $signed({1'b0, dmin, 1'b0});
  assign step_minor = (e1 > $signed({2'b00, dmaj}));
  assign err_next   = step_minor ? e1 - $signed({1'b0, dmaj, 1'b0}) : e1;
  assign x_step     = sx_neg ? x - CW'(1) : x + CW'(1);
  assign y_step     = sy_neg ? y - CW'(1) : y + CW'(1);
  assign x_next     = (x_major || step_minor) ? x_step : x;
  assign y_next     = (!x_major || step_minor) ? y_step : y;

  // Decide whether this point ends the line
  assign cur_in  = in_image(x, row_limit) && in_image(y, col_limit);
  assign next_in = in_image(x_next, row_limit) && in_image(y_next, col_limit);
  assign at_end  = x_major ? (x == ex) : (y == ey);
  assign cnt1    = n + 1'b1;
  assign cap     = (cnt1 == CNT_W'(MAX_POINTS));
  assign last    = !cur_in || at_end || cap || !next_in;

  // Handshakes with both queues
  assign emit      = (state == ST_WALK) && !res_full;
  assign load      = !setup_empty && ((state == ST_IDLE) || (emit && last));
  assign setup_pop = load;
  assign res_push  = emit;

  // Build the result item; an empty line gives one invalid item
  always_comb begin
    if (cur_in) begin
      res_data.point_x     = PT_W'(x[CW-2:0]);
      res_data.point_y     = PT_W'(y[CW-2:0]);
      res_data.point_valid = 1'b1;
      res_data.last_point  = last;
      res_data.point_count = cnt1;
      res_data.truncated   = cap && !at_end;
    end else begin
      res_data.point_x     = '0;
      res_data.point_y     = '0;
      res_data.point_valid = 1'b0;
      res_data.last_point  = 1'b1;
      res_data.point_count = '0;
      res_data.truncated   = 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (load) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (emit && last) begin
          state_next = load ? ST_WALK : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold state, load a new line or advance the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    if (load) begin
      x       <= {s_x0[C-1], s_x0};
      y       <= {s_y0[C-1], s_y0};
      ex      <= {s_ex[C-1], s_ex};
      ey      <= {s_ey[C-1], s_ey};
      err     <= '0;
      dmaj    <= s_dmaj;
      dmin    <= s_dmin;
      sx_neg  <= s_sx_neg;
      sy_neg  <= s_sy_neg;
      x_major <= s_x_major;
      n       <= '0;
    end else if (emit && !last) begin
      x   <= x_next;
      y   <= y_next;
      err <= err_next;
      n   <= cnt1;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/clipped_bresenham_line_core.sv */
// Top level of the clipped line rasteriser: register port, front end, queues and walker.
//
// Usage: a line request (start_x, start_y, end_x, end_y) is pushed while full is low.
// The front end works out deltas, directions and the major axis and places the request
// in a two-entry setup queue. The walker takes one request at a time and writes one
// point per cycle into a two-entry result queue; the receiver reads results with pop
// while empty is low. The last result of a line has last_point set; a line with no
// point in the image gives one result with point_valid low.
// From an idle walker, a request passes the setup queue, the walker registers and the
// result queue before its first point is ready. A line gives at most MAX_POINTS points,
// and the walker loads the next request as it writes the last point of a line.
// When the receiver stalls the result queue fills, the walker holds its point, then the
// setup queue fills and full rises. Reset empties both queues, stops the walker and sets
// row_limit and col_limit to 480. The user writes limits through the APB port, row_limit
// at 0x0, col_limit at 0x4, only while no line is in flight, not enforced by the block.
`default_nettype none
module clipped_bresenham_line_core #(
  parameter int MAX_POINTS = bcl_pkg::DEF_MAX_POINTS,
  parameter int COORD_BITS = bcl_pkg::DEF_COORD_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // Request channel
  input  wire logic                         push,
  output logic                              full,
  input  wire logic signed [COORD_BITS-1:0] start_x,
  input  wire logic signed [COORD_BITS-1:0] start_y,
  input  wire logic signed [COORD_BITS-1:0] end_x,
  input  wire logic signed [COORD_BITS-1:0] end_y,
  // Result channel
  output logic                              empty,
  input  wire logic                         pop,
  output logic [bcl_pkg::PT_W-1:0]          point_x,
  output logic [bcl_pkg::PT_W-1:0]          point_y,
  output logic                              point_valid,
  output logic                              last_point,
  output logic [bcl_pkg::CNT_W-1:0]         point_count,
  output logic                              truncated
);
  import bcl_pkg::*;

  localparam int SW = 6 * COORD_BITS + 5;
  localparam int RW = $bits(result_t);

  logic [LIM_W-1:0] row_limit;
  logic [LIM_W-1:0] col_limit;
  logic             cfg_write;
  reg_idx_t         cfg_idx;

  logic             setup_push;
  logic [SW-1:0]    setup_wr;
  logic             setup_full;
  logic             setup_pop;
  logic [SW-1:0]    setup_rd;
  logic             setup_empty;

  logic             res_push;
  logic             res_full;
  result_t          res_wr;
  logic [RW-1:0]    res_rd;
  result_t          res_out;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_limit <= ROW_LIMIT_RESET;
      col_limit <= COL_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_ROW_LIMIT: row_limit <= pwdata[LIM_W-1:0];
        REG_COL_LIMIT: col_limit <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      REG_ROW_LIMIT: prdata = 32'(row_limit);
      REG_COL_LIMIT: prdata = 32'(col_limit);
      default:       prdata = '0;
    endcase
  end

  bcl_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .push       (push),
    .full       (full),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .setup_full (setup_full),
    .setup_push (setup_push),
    .setup_data (setup_wr)
  );

  bcl_fifo #(
    .WIDTH(SW),
    .DEPTH(QUEUE_DEPTH)
  ) u_setup_q (
    .clk     (clk),
    .rst     (rst),
    .push    (setup_push),
    .wr_data (setup_wr),
    .full    (setup_full),
    .pop     (setup_pop),
    .rd_data (setup_rd),
    .empty   (setup_empty)
  );

  bcl_walker #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_walker (
    .clk         (clk),
    .rst         (rst),
    .row_limit   (row_limit),
    .col_limit   (col_limit),
    .setup_data  (setup_rd),
    .setup_empty (setup_empty),
    .setup_pop   (setup_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_data    (res_wr)
  );

  bcl_fifo #(
    .WIDTH(RW),
    .DEPTH(QUEUE_DEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_rd),
    .empty   (empty)
  );

  // Drive the result ports from the oldest queued item
  assign res_out     = result_t'(res_rd);
  assign point_x     = res_out.point_x;
  assign point_y     = res_out.point_y;
  assign point_valid = res_out.point_valid;
  assign last_point  = res_out.last_point;
  assign point_count = res_out.point_count;
  assign truncated   = res_out.truncated;

endmodule
`default_nettype wire

/* bench/tb_clipped_bresenham_line_core.sv */
// Testbench for the clipped line rasteriser: directed table, random lines, limit changes.
`timescale 1ns / 100ps
module tb_clipped_bresenham_line_core;
  import bcl_pkg::*;

  localparam int CAP        = DEF_MAX_POINTS;
  localparam int CW         = DEF_COORD_BITS;
  localparam int QUIET_MAX  = 5000;
  localparam int SHOW_MAX   = 30;
  localparam int N_DIRECTED = 24;

  // One line request; the typed fields hold the single result where it is known by eye
  typedef struct {
    int sx, sy, ex, ey;
    int typed;
    int px, py, vld, lst, cnt, trc;
  } line_case_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [2:0]        paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  logic              push    = 1'b0;
  logic              full;
  logic signed [CW-1:0] start_x = '0;
  logic signed [CW-1:0] start_y = '0;
  logic signed [CW-1:0] end_x   = '0;
  logic signed [CW-1:0] end_y   = '0;

  logic              empty;
  logic              pop     = 1'b0;
  logic [PT_W-1:0]   point_x;
  logic [PT_W-1:0]   point_y;
  logic              point_valid;
  logic              last_point;
  logic [CNT_W-1:0]  point_count;
  logic              truncated;

  // Local copy of the limit registers
  int row_lim = 480;
  int col_lim = 480;

  result_t expected_points[$];
  int      err_count    = 0;
  int      quiet_cycles = 0;
  bit      steady       = 1'b0;

  clipped_bresenham_line_core DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .empty(empty), .pop(pop),
    .point_x(point_x), .point_y(point_y), .point_valid(point_valid),
    .last_point(last_point), .point_count(point_count), .truncated(truncated)
  );

  always #6 clk = ~clk;

  // Directed lines, run with the reset limits of 480 x 480
  line_case_t directed_lines [N_DIRECTED] = '{
    '{   0,   0,    0,    0, 1,   0,   0, 1, 1, 1, 0},  // single point at the origin
    '{ 479, 479,  479,  479, 1, 479, 479, 1, 1, 1, 0},  // single point at the far corner
    '{ 480,   0,    0,    0, 1,   0,   0, 0, 1, 0, 0},  // start just right of the image
    '{   0, 480,    0,    0, 1,   0,   0, 0, 1, 0, 0},  // start just below the image
    '{  -1,   5,   10,    5, 1,   0,   0, 0, 1, 0, 0},  // negative start x
    '{-2048, -2048, 2047, 2047, 1, 0,  0, 0, 1, 0, 0},  // most negative start
    '{2047, 2047, -2048, -2048, 1, 0,  0, 0, 1, 0, 0},  // most positive start
    '{   0,   0,   10,    0, 0, 0, 0, 0, 0, 0, 0},      // horizontal
    '{  10,   0,    0,    0, 0, 0, 0, 0, 0, 0, 0},      // horizontal, leftwards
    '{   0,   0,    0,   10, 0, 0, 0, 0, 0, 0, 0},      // vertical
    '{   5,   5,    0,    0, 0, 0, 0, 0, 0, 0, 0},      // diagonal tie, x major
    '{   0,   0,    7,    3, 0, 0, 0, 0, 0, 0, 0},      // shallow
    '{   0,   0,    3,    7, 0, 0, 0, 0, 0, 0, 0},      // steep
    '{  10,  10,    2,    7, 0, 0, 0, 0, 0, 0, 0},      // shallow, both negative
    '{   0,   0,  100,    0, 0, 0, 0, 0, 0, 0, 0},      // cap reached
    '{   0,   0,   63,    0, 0, 0, 0, 0, 0, 0, 0},      // exactly the cap, end reached
    '{   0,   0,   64,    0, 0, 0, 0, 0, 0, 0, 0},      // one past the cap
    '{ 470,   5,  500,    5, 0, 0, 0, 0, 0, 0, 0},      // walks out on the right
    '{   5,   5,  -20,    5, 0, 0, 0, 0, 0, 0, 0},      // walks out on the left
    '{   0,   0, 2047, 2047, 0, 0, 0, 0, 0, 0, 0},      // long diagonal, capped
    '{ 479,   0, -2048,  100, 0, 0, 0, 0, 0, 0, 0},     // long leftward run
    '{ 478, 478, 2047, 2047, 0, 0, 0, 0, 0, 0, 0},      // leaves at the corner
    '{ 416,   0, 1000,    0, 0, 0, 0, 0, 0, 0, 0},      // cap on the last column
    '{   0,   0,   -1,   -1, 0, 0, 0, 0, 0, 0, 0}       // first step leaves the image
  };

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= SHOW_MAX) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Walk a line the way the rasteriser does and queue every point it should give
  function automatic void trace_line(input logic signed [CW-1:0] sx, sy, ex, ey);
    int x = sx;
    int y = sy;
    int xe = ex;
    int ye = ey;
    int dx = xe - x;
    int dy = ye - y;
    int stx = 1;
    int sty = 1;
    int err = 0;
    int n = 0;
    bit x_major;
    bit capped = 1'b0;
    result_t r;
    if (dx < 0) begin
      stx = -1;
      dx = -dx;
    end
    if (dy < 0) begin
      sty = -1;
      dy = -dy;
    end
    x_major = (dy <= dx);
    while (x >= 0 && x < row_lim && y >= 0 && y < col_lim) begin
      r.point_x     = x[PT_W-1:0];
      r.point_y     = y[PT_W-1:0];
      r.point_valid = 1'b1;
      r.last_point  = 1'b0;
      r.point_count = CNT_W'(n + 1);
      r.truncated   = 1'b0;
      expected_points.push_back(r);
      n++;
      if (x_major ? (x == xe) : (y == ye)) break;
      if (n >= CAP) begin
        capped = 1'b1;
        break;
      end
      // advance along the major axis, step the minor one when the error overflows
      if (x_major) begin
        x += stx;
        err += 2 * dy;
        if (err > dx) begin
          y += sty;
          err -= 2 * dx;
        end
      end else begin
        y += sty;
        err += 2 * dx;
        if (err > dy) begin
          x += stx;
          err -= 2 * dy;
        end
      end
    end
    if (n == 0) begin
      r = '0;
      r.last_point = 1'b1;
      expected_points.push_back(r);
    end else begin
      expected_points[expected_points.size() - 1].last_point = 1'b1;
      expected_points[expected_points.size() - 1].truncated  = capped;
    end
  endfunction

  // Push one line request, idling first at random outside the steady stretch, and queue its points once taken
  task automatic send_line(input line_case_t c);
    result_t r;
    if (!steady) begin
      while ($urandom_range(99) < 33) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    push    <= 1'b1;
    start_x <= c.sx[CW-1:0];
    start_y <= c.sy[CW-1:0];
    end_x   <= c.ex[CW-1:0];
    end_y   <= c.ey[CW-1:0];
    do @(posedge clk); while (full);
    if (c.typed != 0) begin
      r.point_x     = c.px[PT_W-1:0];
      r.point_y     = c.py[PT_W-1:0];
      r.point_valid = c.vld[0];
      r.last_point  = c.lst[0];
      r.point_count = c.cnt[CNT_W-1:0];
      r.truncated   = c.trc[0];
      expected_points.push_back(r);
    end else begin
      trace_line(c.sx[CW-1:0], c.sy[CW-1:0], c.ex[CW-1:0], c.ey[CW-1:0]);
    end
  endtask

  // Hold the sender until every queued point has come out, then let the walker settle
  task automatic wait_drained();
    push <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One APB transfer: setup cycle and access cycle, then psel and penable go low again
  task automatic apb_access(input reg_idx_t idx, input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_limits();
    logic [31:0] rd;
    apb_access(REG_ROW_LIMIT, 1'b0, '0, rd);
    if (rd !== 32'(row_lim))
      report_mismatch($sformatf("row_limit reads %0d, want %0d", rd, row_lim));
    apb_access(REG_COL_LIMIT, 1'b0, '0, rd);
    if (rd !== 32'(col_lim))
      report_mismatch($sformatf("col_limit reads %0d, want %0d", rd, col_lim));
  endtask

  // Write both limits with junk in the upper bits, which the register drops
  task automatic set_limits(input int rv, input int cv);
    logic [31:0] rd;
    apb_access(REG_ROW_LIMIT, 1'b1, ($urandom & 32'hFFFF_F800) | 32'(rv), rd);
    row_lim = rv;
    apb_access(REG_COL_LIMIT, 1'b1, ($urandom & 32'hFFFF_F800) | 32'(cv), rd);
    col_lim = cv;
    check_limits();
  endtask

  // Receiver: pop at random, or on every cycle in the steady stretch
  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= steady || ($urandom_range(99) >= 33);
  end

  // Check each popped point against the oldest expected one
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && pop && !empty) begin
      got = '{point_x, point_y, point_valid, last_point, point_count, truncated};
      if (expected_points.size() == 0) begin
        report_mismatch($sformatf("point x=%0d y=%0d with nothing expected",
                                  point_x, point_y));
      end else begin
        want = expected_points.pop_front();
        if (got !== want)
          report_mismatch($sformatf(
            "got x=%0d y=%0d v=%b l=%b n=%0d t=%b, want x=%0d y=%0d v=%b l=%b n=%0d t=%b",
            got.point_x, got.point_y, got.point_valid, got.last_point, got.point_count,
            got.truncated, want.point_x, want.point_y, want.point_valid, want.last_point,
            want.point_count, want.truncated));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (psel && penable)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int          phase_row [8] = '{2047, 1, 0, 2047, 1, 100, 480, 0};
    int          phase_col [8] = '{2047, 1, 480, 1, 2047, 60, 480, 0};
    line_case_t  c;
    int          pick, n_items, rv, cv;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values first, then the directed table
    check_limits();
    for (int i = 0; i < N_DIRECTED; i++) send_line(directed_lines[i]);
    wait_drained();

    // Random lines under a run of limit settings
    for (int p = 0; p < 8; p++) begin
      rv = phase_row[p];
      cv = phase_col[p];
      if (p == 6) begin
        rv = $urandom_range(2047, 1);
        cv = $urandom_range(2047, 1);
      end
      set_limits(rv, cv);
      steady  = (p == 5);
      n_items = (rv == 0 || cv == 0) ? 20 : 60;
      for (int i = 0; i < n_items; i++) begin
        c = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        pick = $urandom_range(99);
        if (pick < 15 || row_lim == 0 || col_lim == 0) begin
          // noise over the whole coordinate range
          c.sx = int'($urandom_range(4095)) - 2048;
          c.sy = int'($urandom_range(4095)) - 2048;
          c.ex = int'($urandom_range(4095)) - 2048;
          c.ey = int'($urandom_range(4095)) - 2048;
        end else begin
          // start inside the image, end near it, inside it or anywhere
          c.sx = $urandom_range(row_lim - 1, 0);
          c.sy = $urandom_range(col_lim - 1, 0);
          pick = $urandom_range(99);
          if (pick < 50) begin
            c.ex = c.sx + int'($urandom_range(160)) - 80;
            c.ey = c.sy + int'($urandom_range(160)) - 80;
          end else if (pick < 80) begin
            c.ex = $urandom_range(row_lim - 1, 0);
            c.ey = $urandom_range(col_lim - 1, 0);
          end else begin
            c.ex = int'($urandom_range(4095)) - 2048;
            c.ey = int'($urandom_range(4095)) - 2048;
          end
        end
        send_line(c);
      end
      wait_drained();
      steady = 1'b0;
    end

    repeat (20) @(posedge clk);
    if (err_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
